[rtl/sct_pkg.sv]
// shared types and constants of the shell command tokenizer
package sct_pkg;

  parameter int unsigned MaxTokenBytesDef = 64;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOL  = 2'd2
  } sct_kind_e;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    sct_kind_e  kind;
    logic [7:0] data;
  } sct_res_t;

  // all results caused by one item
  typedef struct packed {
    logic [2:0]                    cnt;
    logic                          had;
    sct_res_t [MaxResults-1:0]     ent;
  } sct_res_list_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == ChLt) || (c == ChGt) || (c == ChAmp) || (c == ChSemi) || (c == ChPipe);
  endfunction

endpackage

[rtl/sct_in_if.sv]
// input channel of the tokenizer: one command line byte or a line end
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

[rtl/sct_out_if.sv]
// output channel of the tokenizer: token bytes, token ends and line ends
interface sct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       had_tokens;
  logic       last;

  modport source (output valid, output kind, output out_byte, output had_tokens,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input had_tokens,
                input last, output ready);
endinterface

[rtl/shell_command_tokenizer_top.sv]
// top level of the shell command tokenizer: lexer and result buffer
//
//   channel | dir | payload                              | handshake
//   in_i    | in  | char_in[8], line_end                 | valid/ready
//   out_o   | out | kind[2], out_byte[8], had_tokens, last| valid/ready
//
// an item is lexed in the cycle it is accepted; its zero to four results go
// into a result buffer and leave one per cycle while out_o is ready
// the next item is taken in the cycle the last buffered result is taken
// reset clears the lexer to idle between tokens and empties the buffer
module shell_command_tokenizer_top #(
  parameter int unsigned MAX_TOKEN_BYTES = sct_pkg::MaxTokenBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_in_if.sink    in_i,
  sct_out_if.source out_o
);
  import sct_pkg::*;

  sct_res_list_t             res;
  sct_res_t [MaxResults-1:0] ent_q;
  logic [2:0]                cnt_q;
  logic [1:0]                idx_q;
  logic                      had_q;
  logic                      accept;
  logic                      out_fire;
  logic                      at_last;

  assign at_last  = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 3'd0) || (out_fire && at_last);
  assign accept   = in_i.valid && in_i.ready;

  sct_lex #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_lex (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (in_i.char_in),
    .line_end_i(in_i.line_end),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= res.cnt;
      idx_q <= 2'd0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt_q <= 3'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= res.ent;
      had_q <= res.had;
    end
  end

  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.kind       = ent_q[idx_q].kind;
  assign out_o.out_byte   = ent_q[idx_q].data;
  assign out_o.had_tokens = (ent_q[idx_q].kind == KIND_EOL) && had_q;
  assign out_o.last       = at_last;

endmodule

[rtl/sct_lex.sv]
// lexer state and the results of one accepted item
module sct_lex #(
  parameter int unsigned MAX_TOKEN_BYTES = sct_pkg::MaxTokenBytesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             char_i,
  input  logic                   line_end_i,
  output sct_pkg::sct_res_list_t res_o
);
  import sct_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_TOKEN_BYTES + 1);

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeWord   = 2'd1;
  localparam logic [1:0] ModeQuoted = 2'd2;
  localparam logic [1:0] ModeGt     = 2'd3;

  logic [1:0]      mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic            seen_q, seen_d;

  always_comb begin
    logic [2:0] n;
    logic       do_idle;
    logic       do_keep;
    logic       sp;
    logic       op;
    res_o   = '0;
    n       = 3'd0;
    do_idle = 1'b0;
    do_keep = 1'b0;
    mode_d  = mode_q;
    len_d   = len_q;
    seen_d  = seen_q;
    sp      = is_space(char_i);
    op      = is_oper(char_i);

    if (line_end_i) begin
      if (mode_q == ModeGt) begin
        res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: ChGt};
        n = n + 3'd1;
        res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
        n = n + 3'd1;
        seen_d = 1'b1;
      end else if (len_q != '0) begin
        res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
        n = n + 3'd1;
        seen_d = 1'b1;
      end
      res_o.ent[n[1:0]] = '{kind: KIND_EOL, data: 8'h00};
      n = n + 3'd1;
      res_o.had = seen_d;
      mode_d = ModeIdle;
      len_d  = '0;
      seen_d = 1'b0;
    end else begin
      unique case (mode_q)
        ModeIdle: do_idle = 1'b1;
        ModeWord: begin
          if (sp || op) begin
            if (len_q != '0) begin
              res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
              n = n + 3'd1;
              seen_d = 1'b1;
            end
            do_idle = 1'b1;
          end else begin
            do_keep = 1'b1;
          end
        end
        ModeQuoted: begin
          if (char_i == ChQuote) begin
            if (len_q != '0) begin
              res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
              n = n + 3'd1;
              seen_d = 1'b1;
            end
            len_d  = '0;
            mode_d = ModeIdle;
          end else begin
            do_keep = 1'b1;
          end
        end
        default: begin
          // held '>' decides between '>>' and a lone '>'
          res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: ChGt};
          n = n + 3'd1;
          if (char_i == ChGt) begin
            res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: ChGt};
            n = n + 3'd1;
          end else begin
            do_idle = 1'b1;
          end
          res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
          n = n + 3'd1;
          seen_d = 1'b1;
          len_d  = '0;
          mode_d = ModeIdle;
        end
      endcase

      if (do_idle) begin
        len_d = '0;
        priority if (sp) begin
          mode_d = ModeIdle;
        end else if (char_i == ChQuote) begin
          mode_d = ModeQuoted;
        end else if (char_i == ChGt) begin
          mode_d = ModeGt;
        end else if (op) begin
          res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: char_i};
          n = n + 3'd1;
          res_o.ent[n[1:0]] = '{kind: KIND_END, data: 8'h00};
          n = n + 3'd1;
          seen_d = 1'b1;
          mode_d = ModeIdle;
        end else begin
          // first byte of a word always fits
          res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: char_i};
          n = n + 3'd1;
          len_d  = LenW'(1);
          mode_d = ModeWord;
        end
      end

      if (do_keep && (len_q < LenW'(MAX_TOKEN_BYTES))) begin
        res_o.ent[n[1:0]] = '{kind: KIND_BYTE, data: char_i};
        n = n + 3'd1;
        len_d = len_q + LenW'(1);
      end
    end
    res_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      len_q  <= '0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      seen_q <= seen_d;
    end
  end

endmodule

[tb/shell_command_tokenizer_top_test.sv]
// testbench of the shell command tokenizer: directed and random lines, results checked in order
module shell_command_tokenizer_top_test;
  import sct_pkg::*;

  localparam int unsigned TokMax = MaxTokenBytesDef;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;
  localparam logic [7:0] ChNl = 8'h0A;

  typedef enum logic [1:0] {
    LX_IDLE,
    LX_WORD,
    LX_QUOTED,
    LX_GT
  } lex_mode_e;

  typedef struct {
    sct_kind_e  kind;
    logic [7:0] data;
    logic       had;
    logic       last;
  } tok_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sct_in_if  in_ch ();
  sct_out_if out_ch ();

  shell_command_tokenizer_top #(
    .MAX_TOKEN_BYTES(TokMax)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer state as the block should hold it
  lex_mode_e   lx_mode = LX_IDLE;
  int unsigned lx_len = 0;
  logic        lx_seen = 1'b0;

  tok_result_t step_q[$];
  tok_result_t tok_due_q[$];

  int   fails = 0;
  int   items_sent = 0;
  int   tx_gap_max = 5;
  int   rx_gap_max = 5;
  logic hold_req = 1'b0;

  function automatic logic blank_byte(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic op_byte(input logic [7:0] c);
    return (c == ChLt) || (c == ChGt) || (c == ChAmp) || (c == ChSemi) || (c == ChPipe);
  endfunction

  function automatic void add_result(input sct_kind_e k, input logic [7:0] b, input logic h);
    tok_result_t r;
    if (step_q.size() >= MaxResults) return;
    r.kind = k;
    r.data = b;
    r.had  = h;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void keep_tok_byte(input logic [7:0] c);
    // bytes past the limit are swallowed
    if (lx_len < TokMax) begin
      add_result(KIND_BYTE, c, 1'b0);
      lx_len++;
    end
  endfunction

  function automatic void close_tok();
    if (lx_len > 0) begin
      add_result(KIND_END, 8'h00, 1'b0);
      lx_seen = 1'b1;
    end
    lx_len  = 0;
    lx_mode = LX_IDLE;
  endfunction

  function automatic void op_tok(input logic [7:0] c);
    add_result(KIND_BYTE, c, 1'b0);
    add_result(KIND_END, 8'h00, 1'b0);
    lx_seen = 1'b1;
    lx_len  = 0;
    lx_mode = LX_IDLE;
  endfunction

  function automatic void start_tok(input logic [7:0] c);
    lx_len = 0;
    if (blank_byte(c)) begin
      lx_mode = LX_IDLE;
    end else if (c == ChQuote) begin
      lx_mode = LX_QUOTED;
    end else if (c == ChGt) begin
      lx_mode = LX_GT;
    end else if (op_byte(c)) begin
      op_tok(c);
    end else begin
      lx_mode = LX_WORD;
      keep_tok_byte(c);
    end
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic le);
    step_q.delete();
    if (le) begin
      if (lx_mode == LX_GT) op_tok(ChGt);
      else close_tok();
      add_result(KIND_EOL, 8'h00, lx_seen);
      lx_mode = LX_IDLE;
      lx_len  = 0;
      lx_seen = 1'b0;
    end else begin
      case (lx_mode)
        LX_IDLE: start_tok(c);
        LX_WORD: begin
          if (blank_byte(c) || op_byte(c)) begin
            close_tok();
            start_tok(c);
          end else begin
            keep_tok_byte(c);
          end
        end
        LX_QUOTED: begin
          if (c == ChQuote) close_tok();
          else keep_tok_byte(c);
        end
        default: begin
          // held '>' decides between '>>' and a lone '>'
          if (c == ChGt) begin
            add_result(KIND_BYTE, ChGt, 1'b0);
            op_tok(ChGt);
          end else begin
            op_tok(ChGt);
            start_tok(c);
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) tok_due_q.push_back(step_q[i]);
  endfunction

  function automatic void check_result();
    tok_result_t want;
    if (tok_due_q.size() == 0) begin
      $error("unexpected result: kind %0d out_byte %02h", out_ch.kind, out_ch.out_byte);
      fails++;
      return;
    end
    want = tok_due_q.pop_front();
    if (out_ch.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
      fails++;
    end
    if (out_ch.out_byte !== want.data) begin
      $error("out_byte: expected %02h, actual %02h", want.data, out_ch.out_byte);
      fails++;
    end
    if (out_ch.had_tokens !== want.had) begin
      $error("had_tokens: expected %0b, actual %0b", want.had, out_ch.had_tokens);
      fails++;
    end
    if (out_ch.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, out_ch.last);
      fails++;
    end
  endfunction

  // called at a rising edge; returns at the edge that took the item
  task automatic send_item(input logic [7:0] c, input logic le);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.line_end <= le;
    do @(negedge clk_i); while (!in_ch.ready);
    predict_tokens(c, le);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic end_line(input logic [7:0] c);
    send_item(c, 1'b1);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_word_byte();
    logic [7:0] c;
    do c = rand_byte(); while (blank_byte(c) || op_byte(c) || c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] rand_quoted_byte();
    logic [7:0] c;
    do c = rand_byte(); while (c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] rand_blank_byte();
    int n;
    n = $urandom_range(0, 5);
    return (n == 5) ? ChSpace : ChTab + 8'(n);
  endfunction

  function automatic logic [7:0] rand_op_byte();
    case ($urandom_range(0, 4))
      0: return ChLt;
      1: return ChGt;
      2: return ChAmp;
      3: return ChSemi;
      default: return ChPipe;
    endcase
  endfunction

  task automatic send_random_token();
    int sel;
    int n;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(rand_word_byte(), 1'b0);
      end
      3: begin
        // quote in the middle of a word
        send_item(rand_word_byte(), 1'b0);
        send_item(ChQuote, 1'b0);
        send_item(rand_word_byte(), 1'b0);
      end
      4, 5: begin
        send_item(ChQuote, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_item(rand_quoted_byte(), 1'b0);
        if ($urandom_range(0, 7) != 0) send_item(ChQuote, 1'b0);
      end
      6: send_item(rand_op_byte(), 1'b0);
      7: begin
        send_item(ChGt, 1'b0);
        send_item(ChGt, 1'b0);
      end
      default: begin
        send_item(rand_word_byte(), 1'b0);
        send_item(rand_op_byte(), 1'b0);
      end
    endcase
    if ($urandom_range(0, 9) < 7) send_item(rand_blank_byte(), 1'b0);
  endtask

  task automatic send_random_line();
    int sel;
    int n;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      n = $urandom_range(1, 12);
      repeat (n) send_item(rand_byte(), 1'b0);
    end else if (sel == 2) begin
      n = $urandom_range(60, 72);
      if ($urandom_range(0, 1) == 1) send_item(ChQuote, 1'b0);
      repeat (n) send_item(rand_word_byte(), 1'b0);
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) send_random_token();
    end
    end_line(rand_byte());
  endtask

  task automatic test_operators();
    tx_gap_max = 5;
    rx_gap_max = 5;
    send_text("a<b>>c>d");
    end_line(ChGt);
    // lone '>' before another operator, then one held at the line end
    send_text("&;|>< >");
    end_line(8'h00);
  endtask

  task automatic test_quotes();
    send_text("q\"r \"\"\"s t\"u \"v");
    end_line(8'hFF);
    end_line(ChNl);
  endtask

  task automatic test_odd_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h0B, 1'b0);
    send_item(8'h0C, 1'b0);
    send_item(8'h0D, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(ChQuote, 1'b0);
    end_line(8'h55);
  endtask

  task automatic test_long_token();
    tx_gap_max = 1;
    rx_gap_max = 1;
    repeat (TokMax + 6) send_item(rand_word_byte(), 1'b0);
    send_item(ChSpace, 1'b0);
    send_item(ChQuote, 1'b0);
    repeat (TokMax + 2) send_item(rand_quoted_byte(), 1'b0);
    send_item(ChQuote, 1'b0);
    end_line(8'hAA);
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_req   = 1'b1;
    send_text("<&;|<&;|>< a b");
    end_line(8'h0F);
  endtask

  task automatic test_random_lines(input int n_items, input int tx_max, input int rx_max);
    int stop_at;
    stop_at    = items_sent + n_items;
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    while (items_sent < stop_at) send_random_line();
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk_i); while (!out_ch.valid);
      check_result();
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(negedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int waited;
    in_ch.valid    = 1'b0;
    in_ch.char_in  = 8'h00;
    in_ch.line_end = 1'b0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operators();
    test_quotes();
    test_odd_bytes();
    test_long_token();
    test_backpressure();
    test_random_lines(90, 5, 5);
    test_random_lines(55, 0, 0);
    test_random_lines(55, 0, 5);
    test_random_lines(50, 5, 0);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (tok_due_q.size() > 0 && waited < StallLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (tok_due_q.size() > 0) begin
      $error("%0d results never arrived", tok_due_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sct_pkg.sv
rtl/sct_in_if.sv
rtl/sct_out_if.sv
rtl/sct_lex.sv
rtl/shell_command_tokenizer_top.sv
tb/shell_command_tokenizer_top_test.sv
